FILE: sv/round_robin_sleep_scheduler_top_macros.svh
// Assertion macros for the round-robin sleep scheduler checker
`ifndef ROUND_ROBIN_SLEEP_SCHEDULER_TOP_MACROS_SVH
`define ROUND_ROBIN_SLEEP_SCHEDULER_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define RRS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrs check failed");
// next-cycle implication checked on every clock edge outside reset
`define RRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrs check failed");
`endif

FILE: sv/rrs_pkg.sv
// Shared types and constants for the round-robin sleep scheduler
package rrs_pkg;
  localparam int TASK_SLOTS_DEF  = 16;
  localparam int MS_PER_TICK_DEF = 10;
  localparam int ID_W            = 4;
  localparam int MS_W            = 32;
  localparam int MIN_W           = 10;
  localparam logic [MIN_W-1:0] MIN_SLEEP_RST = 10'd10;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READY = 2'd1,
    OP_SLEEP = 2'd2,
    OP_YIELD = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]      op;
    logic [ID_W-1:0] task_id;
    logic [MS_W-1:0] sleep_ms;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0] running_task;
    logic            idle_running;
    logic [1:0]      status;
  } out_word_t;
endpackage

FILE: sv/rrs_if.sv
// Valid/ready channel interfaces for scheduler input and result words
interface rrs_in_if;
  import rrs_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rrs_out_if;
  import rrs_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/rrs_tick_div.sv
// Constant divider: milliseconds to ticks by reciprocal multiplication, product then quotient registered
module rrs_tick_div #(
  parameter int MS_PER_TICK = rrs_pkg::MS_PER_TICK_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [rrs_pkg::MS_W-1:0] dividend,
  output logic                     done,
  output logic [rrs_pkg::MS_W-1:0] quotient
);
  import rrs_pkg::*;
  // q = floor(x * (2^MS_W + MAGIC) / 2^(MS_W + SH)), exact for every MS_W-bit x
  localparam int SH = $clog2(MS_PER_TICK);
  localparam longint unsigned MAGIC_L =
    ((64'd1 << MS_W) * ((64'd1 << SH) - 64'(MS_PER_TICK))) / 64'(MS_PER_TICK) + 64'd1;
  localparam logic [MS_W-1:0] MAGIC = MS_W'(MAGIC_L);

  logic              stage1;
  logic [MS_W-1:0]   x_hold;
  logic [2*MS_W-1:0] prod_lo;
  logic [2*MS_W:0]   prod;
  logic [2*MS_W:0]   shifted;

  // add the implicit top bit of the reciprocal, then drop the fraction
  assign prod    = {1'b0, prod_lo} + {1'b0, x_hold, {MS_W{1'b0}}};
  assign shifted = prod >> (MS_W + SH);

  // stage flags
  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      done   <= stage1;
    end
  end

  // multiply, then sum and shift
  always_ff @(posedge clk) begin
    if (start) begin
      x_hold  <= dividend;
      prod_lo <= (2*MS_W)'(dividend) * (2*MS_W)'(MAGIC);
    end
    if (stage1) quotient <= shifted[MS_W-1:0];
  end
endmodule

FILE: sv/rrs_engine.sv
// List engine: ready, sleep and countdown memories walked by a sequencer
module rrs_engine #(
  parameter int TASK_SLOTS  = rrs_pkg::TASK_SLOTS_DEF,
  parameter int MS_PER_TICK = rrs_pkg::MS_PER_TICK_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rrs_pkg::MIN_W-1:0] min_sleep_ms,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rrs_pkg::in_word_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rrs_pkg::out_word_t        out_data
);
  import rrs_pkg::*;
  localparam int PW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam int IDS = 1 << ID_W;
  localparam logic [CW-1:0] FULL = CW'(TASK_SLOTS);

  typedef enum logic [4:0] {
    S_IDLE, S_RSCAN, S_RCMP, S_SSCAN, S_SCMP, S_DIV, S_DIVW, S_SDEC,
    S_RSHR, S_RSHW, S_SAPP, S_TRD, S_TRD2, S_TCHK, S_SSHR, S_SSHW,
    S_HRD, S_HCHK, S_RROT, S_RROTW, S_OUT
  } state_t;

  // memories, one write port and one registered read each
  logic [ID_W-1:0] ready_mem [TASK_SLOTS];
  logic [ID_W-1:0] sleep_mem [TASK_SLOTS];
  logic [MS_W-1:0] ticks_mem [IDS];

  logic            r_we, s_we, t_we;
  logic [PW-1:0]   r_wa, r_ra, s_wa, s_ra;
  logic [ID_W-1:0] r_wd, s_wd, r_rd, s_rd, t_wa, t_ra;
  logic [MS_W-1:0] t_wd, t_rd;

  always_ff @(posedge clk) begin
    if (r_we) ready_mem[r_wa] <= r_wd;
    r_rd <= ready_mem[r_ra];
  end
  always_ff @(posedge clk) begin
    if (s_we) sleep_mem[s_wa] <= s_wd;
    s_rd <= sleep_mem[s_ra];
  end
  always_ff @(posedge clk) begin
    if (t_we) ticks_mem[t_wa] <= t_wd;
    t_rd <= ticks_mem[t_ra];
  end

  state_t          state;
  logic [1:0]      op;
  logic [ID_W-1:0] tid, head;
  logic [MS_W-1:0] ms, ticks;
  logic [CW-1:0]   rcnt, scnt, idx;
  logic [PW-1:0]   rpos, spos;
  logic            rfound, sfound;
  logic [ID_W-1:0] cur;
  logic            idle;
  logic [1:0]      status;
  logic            div_start, div_done;
  logic [MS_W-1:0] div_q;

  rrs_tick_div #(.MS_PER_TICK(MS_PER_TICK)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(ms),
    .done(div_done), .quotient(div_q)
  );

  assign in_ready = (state == S_IDLE);
  assign out_data.running_task = idle ? '0 : cur;
  assign out_data.idle_running = idle;

  // memory port control from state
  always_comb begin
    r_we = 1'b0; s_we = 1'b0; t_we = 1'b0;
    r_wa = '0; s_wa = '0; r_wd = '0; s_wd = '0; t_wa = '0; t_wd = '0;
    r_ra = idx[PW-1:0]; s_ra = idx[PW-1:0]; t_ra = s_rd;
    div_start = 1'b0;
    case (state)
      S_DIV:  div_start = 1'b1;
      S_RSHR: r_ra = PW'(idx + 1'b1);
      S_RSHW: begin
        r_we = 1'b1; r_wa = idx[PW-1:0]; r_wd = r_rd;
      end
      // a zero-tick sleep joins no list
      S_SAPP: begin
        t_we = (ticks != '0); t_wa = cur; t_wd = ticks;
        s_we = !sfound && (ticks != '0); s_wa = scnt[PW-1:0]; s_wd = cur;
      end
      S_SSHR: s_ra = PW'(idx + 1'b1);
      S_SSHW: begin
        s_we = 1'b1; s_wa = idx[PW-1:0]; s_wd = s_rd;
      end
      S_TCHK: begin
        t_we = 1'b1; t_wa = s_rd;
        if (t_rd == MS_W'(1) && rcnt == FULL) t_wd = MS_W'(1);
        else t_wd = t_rd - 1'b1;
        if (t_rd == MS_W'(1) && rcnt != FULL) begin
          r_we = 1'b1; r_wa = rcnt[PW-1:0]; r_wd = s_rd;
        end
      end
      S_HRD:  r_ra = '0;
      S_RROTW: begin
        r_we = 1'b1; r_wa = PW'(rcnt - 1'b1); r_wd = head;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; rcnt <= '0; scnt <= '0; cur <= '0; idle <= 1'b1;
      out_valid <= 1'b0; idx <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          op <= in_data.op; ms <= in_data.sleep_ms;
          tid <= (op_t'(in_data.op) == OP_SLEEP) ? cur : in_data.task_id;
          status <= ST_OK; idx <= '0; rfound <= 1'b0; sfound <= 1'b0;
          case (op_t'(in_data.op))
            OP_READY: state <= S_RSCAN;
            OP_SLEEP: state <= idle ? S_HRD : S_RSCAN;
            OP_TICK:  state <= S_TRD;
            default:  state <= S_HRD;
          endcase
        end
        // linear search of the ready list
        S_RSCAN: state <= (idx < rcnt) ? S_RCMP : S_SSCAN;
        S_RCMP: begin
          if (!rfound && r_rd == tid) begin
            rfound <= 1'b1; rpos <= idx[PW-1:0];
          end
          if (idx + 1'b1 < rcnt) idx <= idx + 1'b1;
          else begin
            idx <= '0; state <= S_SSCAN;
          end
          if (idx + 1'b1 < rcnt) state <= S_RSCAN;
        end
        S_SSCAN: begin
          if (idx < scnt) state <= S_SCMP;
          else if (op == OP_READY) begin
            if (rfound || sfound) status <= ST_DUP;
            else if (rcnt == FULL) status <= ST_FULL;
            state <= (rfound || sfound || rcnt == FULL) ? S_OUT : S_RROTW;
            head <= tid;
            if (!(rfound || sfound || rcnt == FULL)) rcnt <= rcnt + 1'b1;
          end else begin
            if (ms < MS_W'(min_sleep_ms)) ms <= MS_W'(min_sleep_ms);
            state <= S_DIV;
          end
        end
        S_SCMP: begin
          if (!sfound && s_rd == tid) begin
            sfound <= 1'b1; spos <= idx[PW-1:0];
          end
          idx <= idx + 1'b1;
          state <= S_SSCAN;
        end
        S_DIV: state <= S_DIVW;
        S_DIVW: if (div_done) begin
          ticks <= div_q;
          if (div_q != '0 && !sfound && scnt == FULL) begin
            status <= ST_FULL; state <= S_HRD;
          end else if (rfound) begin
            idx <= CW'(rpos); state <= S_RSHR;
          end else state <= (div_q != '0) ? S_SAPP : S_HRD;
        end
        // close the gap in the ready list; a schedule rotation ends in the tail write
        S_RSHR: begin
          if (idx + 1'b1 < rcnt) state <= S_RSHW;
          else if (op == OP_YIELD && !rfound) state <= S_RROT;
          else state <= S_SAPP;
        end
        S_RSHW: begin
          idx <= idx + 1'b1; state <= S_RSHR;
        end
        S_SAPP: begin
          if (rfound) rcnt <= rcnt - 1'b1;
          rfound <= 1'b0;
          if (ticks != '0) begin
            if (!sfound) scnt <= scnt + 1'b1;
          end
          state <= S_HRD;
        end
        // tick walk: read sleeper, then its count
        S_TRD: begin
          if (idx < scnt) state <= S_TRD2;
          else state <= S_HRD;
        end
        S_TRD2: state <= S_TCHK;
        S_TCHK: begin
          if (t_rd == MS_W'(1) && rcnt != FULL) begin
            rcnt <= rcnt + 1'b1;
            spos <= idx[PW-1:0];
            state <= S_SSHR;
          end else begin
            if (t_rd == MS_W'(1)) status <= ST_FULL;
            idx <= idx + 1'b1; state <= S_TRD;
          end
        end
        // remove woken sleeper, then resume the walk at the same place
        S_SSHR: state <= (idx + 1'b1 < scnt) ? S_SSHW : S_TRD;
        S_SSHW: begin
          idx <= idx + 1'b1; state <= S_SSHR;
        end
        S_HRD: state <= S_HCHK;
        S_HCHK: begin
          if (rcnt == '0 || (!idle && r_rd == cur)) begin
            idle <= 1'b1; state <= S_OUT;
          end else begin
            head <= r_rd; cur <= r_rd; idle <= 1'b0;
            idx <= '0; state <= S_RSHR;
            op <= OP_YIELD; rfound <= 1'b0;
          end
        end
        S_RROT: state <= S_RROTW;
        S_RROTW: state <= S_OUT;
        S_OUT: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0; state <= S_IDLE;
          end else out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
      // sleep-list walk restart after shifting
      if (state == S_SSHR && !(idx + 1'b1 < scnt)) begin
        scnt <= scnt - 1'b1; idx <= CW'(spos);
      end
    end
  end

  assign out_data.status = status;
endmodule

FILE: sv/round_robin_sleep_scheduler_top.sv
// Top level of the round-robin sleep scheduler
// channel   dir  payload
// cmd       in   op, task_id, sleep_ms
// rsp       out  running_task, idle_running, status
// cfg       in   min_sleep_ms (write enable + data)
// List scans and shifts go one entry at a time, the tick walk visits each sleeper in
// turn, and a sleep adds a reciprocal divide.
// One item at a time; the next word is taken the cycle after the result word is
// accepted, and the result is held until taken. Reset is synchronous; no memory
// clearing pass is needed.
module round_robin_sleep_scheduler_top #(
  parameter int TASK_SLOTS  = rrs_pkg::TASK_SLOTS_DEF,
  parameter int MS_PER_TICK = rrs_pkg::MS_PER_TICK_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [rrs_pkg::MIN_W-1:0] cfg_wdata,
  rrs_in_if.sink                    cmd,
  rrs_out_if.source                 rsp
);
  import rrs_pkg::*;
  logic [MIN_W-1:0] min_sleep_ms;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) min_sleep_ms <= MIN_SLEEP_RST;
    else if (cfg_we) min_sleep_ms <= cfg_wdata;
  end

  rrs_engine #(.TASK_SLOTS(TASK_SLOTS), .MS_PER_TICK(MS_PER_TICK)) u_engine (
    .clk(clk), .rst(rst), .min_sleep_ms(min_sleep_ms),
    .in_valid(cmd.valid), .in_ready(cmd.ready), .in_data(cmd.data),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
  );
endmodule

FILE: sv/rrs_checker.sv
// Port-level checker for the scheduler, bound to the top level
`include "round_robin_sleep_scheduler_top_macros.svh"
module rrs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rrs_pkg::out_word_t out_data
);
  import rrs_pkg::*;
  `RRS_ASSERT_IMP(a_idle_zero, clk, rst, out_valid && out_data.idle_running, out_data.running_task == '0)
  `RRS_ASSERT_IMP(a_status_code, clk, rst, out_valid, out_data.status != 2'd3)
  `RRS_ASSERT_IMP(a_no_take_while_busy, clk, rst, out_valid, !in_ready)
  `RRS_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready)
  `RRS_ASSERT_NEXT(a_hold_result, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind round_robin_sleep_scheduler_top rrs_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(cmd.valid), .in_ready(cmd.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
);

FILE: tb/sv/round_robin_sleep_scheduler_top_test.sv
// Self-checking testbench for the round-robin sleep scheduler top level
module round_robin_sleep_scheduler_top_test;
  import rrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [MIN_W-1:0] cfg_wdata = '0;

  rrs_in_if  cmd ();
  rrs_out_if rsp ();

  round_robin_sleep_scheduler_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .cmd(cmd.sink), .rsp(rsp.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler shadow state
  logic [ID_W-1:0]  rdy_list [SLOTS];
  int               rdy_n;
  logic [ID_W-1:0]  slp_list [SLOTS];
  int               slp_n;
  logic [31:0]      ticks_to_wake [16];
  logic [ID_W-1:0]  cur_task;
  logic             idle_on;
  logic [MIN_W-1:0] min_ms;

  out_word_t pending_q [$];
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic int find_in(ref logic [ID_W-1:0] lst [SLOTS], input int n,
                                 input logic [ID_W-1:0] id);
    for (int i = 0; i < n; i++) if (lst[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_ready(int pos);
    for (int i = pos; i + 1 < rdy_n; i++) rdy_list[i] = rdy_list[i+1];
    rdy_n--;
  endfunction

  function automatic void drop_sleeper(int pos);
    for (int i = pos; i + 1 < slp_n; i++) slp_list[i] = slp_list[i+1];
    slp_n--;
  endfunction

  function automatic void pick_next();
    logic [ID_W-1:0] head;
    if (rdy_n == 0) begin
      idle_on = 1'b1;
      return;
    end
    head = rdy_list[0];
    if (!idle_on && head == cur_task) begin
      idle_on = 1'b1;
      return;
    end
    drop_ready(0);
    rdy_list[rdy_n++] = head;
    cur_task = head;
    idle_on = 1'b0;
  endfunction

  // compute the outcome of one command word and advance the shadow state
  function automatic out_word_t next_schedule(in_word_t w);
    out_word_t r;
    status_t st;
    logic [31:0] ms, tk;
    int rpos, spos, i;
    logic [ID_W-1:0] t;
    st = ST_OK;
    case (op_t'(w.op))
      OP_READY: begin
        if (find_in(rdy_list, rdy_n, w.task_id) >= 0 ||
            find_in(slp_list, slp_n, w.task_id) >= 0) st = ST_DUP;
        else if (rdy_n >= SLOTS) st = ST_FULL;
        else rdy_list[rdy_n++] = w.task_id;
      end
      OP_SLEEP: begin
        if (!idle_on) begin
          t = cur_task;
          rpos = find_in(rdy_list, rdy_n, t);
          spos = find_in(slp_list, slp_n, t);
          ms = (w.sleep_ms < 32'(min_ms)) ? 32'(min_ms) : w.sleep_ms;
          tk = ms / 10;
          if (tk >= 1 && spos < 0 && slp_n >= SLOTS) st = ST_FULL;
          else begin
            if (rpos >= 0) drop_ready(rpos);
            if (tk >= 1) begin
              ticks_to_wake[t] = tk;
              if (spos < 0) slp_list[slp_n++] = t;
            end
          end
        end
        pick_next();
      end
      OP_TICK: begin
        i = 0;
        while (i < slp_n) begin
          t = slp_list[i];
          ticks_to_wake[t] = ticks_to_wake[t] - 1;
          if (ticks_to_wake[t] == 0) begin
            if (rdy_n < SLOTS) begin
              rdy_list[rdy_n++] = t;
              drop_sleeper(i);
              continue;
            end
            ticks_to_wake[t] = 1;
            st = ST_FULL;
          end
          i++;
        end
        pick_next();
      end
      default: pick_next();
    endcase
    r.running_task = idle_on ? '0 : cur_task;
    r.idle_running = idle_on;
    r.status = st;
    return r;
  endfunction

  // send one command word and queue its expected outcome
  task automatic send_word(in_word_t w);
    out_word_t exp_r;
    exp_r = next_schedule(w);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    pending_q.push_back(exp_r);
    cmd.valid <= 1'b1;
    cmd.data <= w;
    do @(posedge clk); while (!cmd.ready);
    words_sent++;
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_min_sleep(logic [MIN_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    min_ms = v;
  endtask

  // random ready-strobe on the result side
  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each taken result word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", rsp.data);
      end else begin
        out_word_t e;
        e = pending_q.pop_front();
        words_checked++;
        if (rsp.data.running_task !== e.running_task ||
            rsp.data.idle_running !== e.idle_running ||
            rsp.data.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected task %0d idle %0b status %0d, got %0d %0b %0d",
                     e.running_task, e.idle_running, e.status,
                     rsp.data.running_task, rsp.data.idle_running, rsp.data.status);
        end
      end
    end
  end

  // directed table: op, task, ms, check flag, expected result where obvious
  typedef struct {
    op_t         op;
    logic [3:0]  id;
    logic [31:0] ms;
    logic        typed;
    out_word_t   res;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic dir_row_t row(op_t o, logic [3:0] id, logic [31:0] ms,
                                   logic typed = 0, out_word_t res = '0);
    dir_row_t d;
    d.op = o; d.id = id; d.ms = ms; d.typed = typed; d.res = res;
    return d;
  endfunction

  // one random word, mostly well-formed scheduler traffic
  function automatic in_word_t rand_word();
    in_word_t w;
    int p;
    p = $urandom_range(99);
    w.task_id = $urandom_range(15);
    w.sleep_ms = $urandom;
    if (p < 30) w.op = OP_READY;
    else if (p < 55) w.op = OP_TICK;
    else if (p < 80) begin
      w.op = OP_SLEEP;
      case ($urandom_range(3))
        0: w.sleep_ms = $urandom_range(9);
        1: w.sleep_ms = $urandom_range(80);
        2: w.sleep_ms = $urandom_range(300);
        default: w.sleep_ms = $urandom;
      endcase
    end else w.op = OP_YIELD;
    return w;
  endfunction

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    in_word_t w;
    out_word_t e;
    cmd.valid = 1'b0;
    cmd.data = '0;
    rdy_n = 0; slp_n = 0; cur_task = '0; idle_on = 1'b1; min_ms = MIN_SLEEP_RST;
    foreach (ticks_to_wake[i]) ticks_to_wake[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: idle behaviour, duplicates, full list, extremes
    dir_rows.push_back(row(OP_YIELD, 4'd0, 32'd0, 1, '{4'd0, 1'b1, ST_OK}));
    dir_rows.push_back(row(OP_TICK, 4'd0, 32'd0, 1, '{4'd0, 1'b1, ST_OK}));
    dir_rows.push_back(row(OP_SLEEP, 4'd0, 32'hFFFF_FFFF, 1, '{4'd0, 1'b1, ST_OK}));
    dir_rows.push_back(row(OP_READY, 4'd15, 32'hFFFF_FFFF, 1, '{4'd0, 1'b1, ST_OK}));
    dir_rows.push_back(row(OP_READY, 4'd15, 32'd0, 1, '{4'd0, 1'b1, ST_DUP}));
    dir_rows.push_back(row(OP_YIELD, 4'd0, 32'd0, 1, '{4'd15, 1'b0, ST_OK}));
    // lone task yields onto itself: idle runs
    dir_rows.push_back(row(OP_YIELD, 4'd0, 32'd0, 1, '{4'd0, 1'b1, ST_OK}));
    for (int i = 0; i < 15; i++) dir_rows.push_back(row(OP_READY, 4'(i), 32'd0));
    dir_rows.push_back(row(OP_READY, 4'd0, 32'd0, 1, '{4'd0, 1'b1, ST_DUP}));
    dir_rows.push_back(row(OP_YIELD, 4'd0, 32'd0));
    dir_rows.push_back(row(OP_SLEEP, 4'd0, 32'hFFFF_FFFF));
    dir_rows.push_back(row(OP_YIELD, 4'd0, 32'd0));
    dir_rows.push_back(row(OP_SLEEP, 4'd0, 32'd0));
    foreach (dir_rows[k]) begin
      w.op = dir_rows[k].op; w.task_id = dir_rows[k].id; w.sleep_ms = dir_rows[k].ms;
      send_word(w);
      if (dir_rows[k].typed) begin
        e = pending_q[$];
        if (e !== dir_rows[k].res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row %0d: typed %p, predicted %p", k, dir_rows[k].res, e);
        end
      end
    end
    drain();
    // random ready and sleep words with short sleeps, which may round to zero ticks
    set_min_sleep(10'd1);
    for (int i = 0; i < 20; i++) begin
      w.op = (i % 3 == 0) ? OP_SLEEP : OP_READY;
      w.task_id = $urandom_range(15); w.sleep_ms = $urandom_range(25);
      send_word(w);
    end

    // random phases under three idling patterns and several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_min_sleep(10'd1000);
        1: set_min_sleep(10'd1);
        2: set_min_sleep(10'd10);
        3: set_min_sleep(10'($urandom_range(1, 1000)));
        4: set_min_sleep(10'd30);
        default: set_min_sleep(10'd1023);
      endcase
      send_idle_pct = (ph < 2) ? 19 : (ph < 4) ? 71 : 0;
      recv_idle_pct = (ph < 2) ? 71 : (ph < 4) ? 19 : 0;
      for (int n = 0; n < 150; n++) begin
        send_word(rand_word());
        // once per phase, hold off until every expected result has been taken
        if (n == 75) begin
          cmd.valid <= 1'b0;
          while (pending_q.size() != 0) @(posedge clk);
        end
      end
    end

    drain();
    $display("Ran %0d command words, %0d results checked, six sleep settings,",
             words_sent, words_checked);
    $display("three handshake idling patterns.");
    if (mismatches == 0 && pending_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
